// ----- design/bole_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the bounded ordered list engine.
// No dependencies; every other file of the block refers to this package.
package bole_pkg;

    // Default number of list positions
    localparam int CAPACITY_DEF = 64;

    // Fixed field widths of the request and response items
    localparam int FUNC_W   = 3;
    localparam int POS_W    = 7;
    localparam int HANDLE_W = 32;

    // All-ones code reported when no position is found
    localparam logic [POS_W-1:0] NOT_FOUND = {POS_W{1'b1}};

    // Requested operation
    typedef enum logic [FUNC_W-1:0] {
        OP_GET        = 3'd0,
        OP_SET        = 3'd1,
        OP_INSERT     = 3'd2,
        OP_APPEND     = 3'd3,
        OP_REMOVE     = 3'd4,
        OP_POP        = 3'd5,
        OP_REMOVE_VAL = 3'd6,
        OP_FIND       = 3'd7
    } op_t;

    // Sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // What each cell does with its entry in one cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_OPEN,
        CELL_CLOSE
    } cell_cmd_t;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        cell_cmd_t             cmd;
        logic                  load_match;
        logic [HANDLE_W-1:0]   handle;
    } cell_ctl_t;

endpackage

// ----- design/bole_if.sv -----
`timescale 1ns / 1ps
// Request and response channel interfaces of the bounded ordered list engine.
// Depends on bole_pkg for field widths.

interface bole_req_if;
    logic                           valid;
    logic                           ready;
    logic [bole_pkg::FUNC_W-1:0]    func;
    logic [bole_pkg::POS_W-1:0]     position;
    logic [bole_pkg::HANDLE_W-1:0]  handle;

    modport source (output valid, output func, output position, output handle, input ready);
    modport sink (input valid, input func, input position, input handle, output ready);
endinterface

interface bole_rsp_if;
    logic                               valid;
    logic                               ready;
    logic                               ok;
    logic [bole_pkg::HANDLE_W-1:0]      returned_handle;
    logic signed [bole_pkg::POS_W-1:0]  found_position;
    logic [bole_pkg::POS_W-1:0]         entry_count;
    logic                               has_room;

    modport source (output valid, output ok, output returned_handle, output found_position,
                    output entry_count, output has_room, input ready);
    modport sink (input valid, input ok, input returned_handle, input found_position,
                  input entry_count, input has_room, output ready);
endinterface

// ----- design/bounded_ordered_list_engine.sv -----
`timescale 1ns / 1ps
// Top level of the bounded ordered list engine: sequencer, output register
// and the row of bole_cell positions. Depends on bole_pkg and bole_if.
//
// Usage:
//   req carries one operation per item (func, position, handle); rsp returns
//   exactly one item per request (ok, returned_handle, found_position,
//   entry_count, has_room). Both are valid/ready channels.
//   At the accept edge every cell compares its handle with the request
//   value; in the execute step that follows, the first-match search, the
//   read and the shift of the whole cell row happen together and the
//   response is loaded into the output register. The execute step waits
//   while a stalled response holds the register; req.ready is high only
//   while idle, so a new request is taken once the previous one executed.
//   A new request is taken while a previous response still waits in the
//   output register. If rsp stalls, the next operation holds in its execute
//   step until the register frees, and req.ready stays low meanwhile.
//   Reset empties the list (count 0) and drops any pending response; no
//   clearing pass is needed since positions at or above the count are never
//   read.
module bounded_ordered_list_engine #(
    parameter int CAPACITY = bole_pkg::CAPACITY_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    bole_req_if.sink   req,
    bole_rsp_if.source rsp
);

    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int W_WIDE = (CNT_W > bole_pkg::POS_W) ? CNT_W : bole_pkg::POS_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // Sequencer and operation registers
    bole_pkg::state_t              state_reg;
    bole_pkg::state_t              state_next;
    bole_pkg::op_t                 op_func_reg;
    logic [bole_pkg::POS_W-1:0]    op_pos_reg;
    logic [bole_pkg::HANDLE_W-1:0] op_handle_reg;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;

    // Output register
    logic                          rsp_valid_reg;
    logic                          ok_reg;
    logic [bole_pkg::HANDLE_W-1:0] ret_reg;
    logic [bole_pkg::POS_W-1:0]    found_reg;
    logic [bole_pkg::POS_W-1:0]    cnt_out_reg;
    logic                          room_reg;

    // Cell row wiring
    logic [bole_pkg::HANDLE_W-1:0] cell_entry [CAPACITY];
    logic [bole_pkg::HANDLE_W-1:0] cell_rd    [CAPACITY];
    logic [CAPACITY-1:0]           match_vec;
    logic [CAPACITY-1:0]           first_vec;
    bole_pkg::cell_ctl_t           ctl;

    // Execute-step decode
    logic                          accept;
    logic                          go;
    logic                          any_match;
    logic [IDX_W-1:0]              enc;
    logic [IDX_W-1:0]              tgt;
    logic                          op_ok;
    logic                          ret_from_cell;
    logic [bole_pkg::HANDLE_W-1:0] rd_or;
    bole_pkg::cell_cmd_t           cmd;
    logic [W_WIDE-1:0]             pos_w;
    logic [W_WIDE-1:0]             cnt_w;
    logic [W_WIDE-1:0]             cnt_dec;
    logic [W_WIDE-1:0]             enc_w;
    logic [W_WIDE-1:0]             cnt_next_w;
    logic                          is_find;

    assign accept = req.valid && req.ready;
    assign go     = (state_reg == bole_pkg::ST_EXEC) && (!rsp_valid_reg || rsp.ready);

    // Isolate the lowest matching position and encode it
    assign first_vec = match_vec & (~match_vec + CAPACITY'(1));
    assign any_match = |match_vec;

    always_comb
    begin
        enc = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (first_vec[i])
            begin
                enc = enc | IDX_W'(i);
            end
        end
    end

    // Gather the addressed cell's entry
    always_comb
    begin
        rd_or = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_or = rd_or | cell_rd[i];
        end
    end

    assign pos_w   = W_WIDE'(op_pos_reg);
    assign cnt_w   = W_WIDE'(count_reg);
    assign cnt_dec = cnt_w - W_WIDE'(1);
    assign enc_w   = W_WIDE'(enc);

    // Decode the operation: success, target position and cell command
    always_comb
    begin
        op_ok         = 1'b0;
        tgt           = pos_w[IDX_W-1:0];
        cmd           = bole_pkg::CELL_HOLD;
        ret_from_cell = 1'b0;
        is_find       = 1'b0;
        count_next    = count_reg;
        case (op_func_reg)
            bole_pkg::OP_GET:
            begin
                op_ok         = pos_w < cnt_w;
                ret_from_cell = 1'b1;
            end
            bole_pkg::OP_SET:
            begin
                op_ok = pos_w < cnt_w;
                cmd   = bole_pkg::CELL_WRITE;
            end
            bole_pkg::OP_INSERT:
            begin
                op_ok      = (count_reg < CAP_CNT) && (pos_w <= cnt_w);
                cmd        = bole_pkg::CELL_OPEN;
                count_next = count_reg + CNT_W'(1);
            end
            bole_pkg::OP_APPEND:
            begin
                op_ok      = count_reg < CAP_CNT;
                tgt        = cnt_w[IDX_W-1:0];
                cmd        = bole_pkg::CELL_OPEN;
                count_next = count_reg + CNT_W'(1);
            end
            bole_pkg::OP_REMOVE:
            begin
                op_ok         = pos_w < cnt_w;
                cmd           = bole_pkg::CELL_CLOSE;
                ret_from_cell = 1'b1;
                count_next    = count_reg - CNT_W'(1);
            end
            bole_pkg::OP_POP:
            begin
                op_ok         = count_reg != '0;
                tgt           = cnt_dec[IDX_W-1:0];
                cmd           = bole_pkg::CELL_CLOSE;
                ret_from_cell = 1'b1;
                count_next    = count_reg - CNT_W'(1);
            end
            bole_pkg::OP_REMOVE_VAL:
            begin
                op_ok         = any_match;
                tgt           = enc;
                cmd           = bole_pkg::CELL_CLOSE;
                ret_from_cell = 1'b1;
                count_next    = count_reg - CNT_W'(1);
            end
            bole_pkg::OP_FIND:
            begin
                op_ok   = any_match;
                tgt     = enc;
                is_find = 1'b1;
            end
            default:
            begin
                op_ok = 1'b0;
            end
        endcase
        if (!op_ok)
        begin
            cmd        = bole_pkg::CELL_HOLD;
            count_next = count_reg;
        end
    end

    assign cnt_next_w = W_WIDE'(count_next);

    // Broadcast control to the cell row
    always_comb
    begin
        ctl.load_match = accept;
        ctl.cmd        = go ? cmd : bole_pkg::CELL_HOLD;
        ctl.handle     = (state_reg == bole_pkg::ST_IDLE) ? req.handle : op_handle_reg;
    end

    // Row of list cells, each wired to its neighbors
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [bole_pkg::HANDLE_W-1:0] prev_entry;
        logic [bole_pkg::HANDLE_W-1:0] next_entry;

        if (g == 0)
        begin : g_first
            assign prev_entry = '0;
        end
        else
        begin : g_mid_lo
            assign prev_entry = cell_entry[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign next_entry = cell_entry[g];
        end
        else
        begin : g_mid_hi
            assign next_entry = cell_entry[g+1];
        end

        bole_cell #(
            .IDX_W (IDX_W),
            .CNT_W (CNT_W),
            .IDX   (g)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .tgt        (tgt),
            .count      (count_reg),
            .prev_entry (prev_entry),
            .next_entry (next_entry),
            .entry      (cell_entry[g]),
            .match      (match_vec[g]),
            .rd_data    (cell_rd[g])
        );
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bole_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = bole_pkg::ST_EXEC;
                end
            end
            bole_pkg::ST_EXEC:
            begin
                if (go)
                begin
                    state_next = bole_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bole_pkg::ST_IDLE;
            end
        endcase
    end

    assign req.ready = (state_reg == bole_pkg::ST_IDLE);

    // Control state: sequencer, count and response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bole_pkg::ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (go)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Latch the request and load the response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_func_reg   <= bole_pkg::op_t'(req.func);
            op_pos_reg    <= req.position;
            op_handle_reg <= req.handle;
        end
        if (go)
        begin
            ok_reg      <= op_ok;
            ret_reg     <= (!op_ok || is_find || op_func_reg == bole_pkg::OP_SET) ? '0 :
                           (ret_from_cell ? rd_or : op_handle_reg);
            found_reg   <= (op_ok && is_find) ? enc_w[bole_pkg::POS_W-1:0] : bole_pkg::NOT_FOUND;
            cnt_out_reg <= cnt_next_w[bole_pkg::POS_W-1:0];
            room_reg    <= count_next < CAP_CNT;
        end
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.ok              = ok_reg;
    assign rsp.returned_handle = ret_reg;
    assign rsp.found_position  = found_reg;
    assign rsp.entry_count     = cnt_out_reg;
    assign rsp.has_room        = room_reg;

    // Count never exceeds the number of cells
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("entry count above capacity");

    // At most one first-match position is selected while an operation executes
    a_first_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bole_pkg::ST_EXEC |-> $onehot0(first_vec))
        else $error("first-match vector not one-hot");

    // An accepted item moves the sequencer to its execute step
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == bole_pkg::ST_EXEC)
        else $error("accepted item not executed");

    // Count changes only when an operation commits
    a_count_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !go |=> $stable(count_reg))
        else $error("count changed without a commit");

    // A reported position always comes with success
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && found_reg != bole_pkg::NOT_FOUND |-> ok_reg)
        else $error("found position without ok");

endmodule

// ----- design/bole_cell.sv -----
`timescale 1ns / 1ps
// One list position: holds a handle, compares it against a search value and
// shifts to or from its neighbors. Depends on bole_pkg.
module bole_cell #(
    parameter int IDX_W = 6,
    parameter int CNT_W = 7,
    parameter int IDX   = 0
) (
    input  logic                           clk,
    input  bole_pkg::cell_ctl_t            ctl,
    input  logic [IDX_W-1:0]               tgt,
    input  logic [CNT_W-1:0]               count,
    input  logic [bole_pkg::HANDLE_W-1:0]  prev_entry,
    input  logic [bole_pkg::HANDLE_W-1:0]  next_entry,
    output logic [bole_pkg::HANDLE_W-1:0]  entry,
    output logic                           match,
    output logic [bole_pkg::HANDLE_W-1:0]  rd_data
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);

    logic [bole_pkg::HANDLE_W-1:0] entry_reg;
    logic [bole_pkg::HANDLE_W-1:0] entry_next;
    logic                          match_reg;
    logic                          at_tgt;
    logic                          above_tgt;

    assign at_tgt    = (MY_IDX == tgt);
    assign above_tgt = (MY_IDX > tgt);

    // Pick the next entry value from the broadcast command
    always_comb
    begin
        entry_next = entry_reg;
        case (ctl.cmd)
            bole_pkg::CELL_WRITE:
            begin
                if (at_tgt)
                begin
                    entry_next = ctl.handle;
                end
            end
            bole_pkg::CELL_OPEN:
            begin
                if (at_tgt)
                begin
                    entry_next = ctl.handle;
                end
                else if (above_tgt)
                begin
                    entry_next = prev_entry;
                end
            end
            bole_pkg::CELL_CLOSE:
            begin
                if (at_tgt || above_tgt)
                begin
                    entry_next = next_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // Hold entry and capture compare result for live positions
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        if (ctl.load_match)
        begin
            match_reg <= (entry_reg == ctl.handle) && (MY_CNT < count);
        end
    end

    assign entry   = entry_reg;
    assign match   = match_reg;
    assign rd_data = at_tgt ? entry_reg : '0;

endmodule
